// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is released
`define SCNM_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// property checked at every edge, reset included
`define SCNM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/scnm_pkg.sv =====
// ----------------------------------------------------------------------------
// scnm_pkg
// shared constants and types of the stroke corner node marker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scnm_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // angle fields
    localparam int ANGLE_BITS = 9;

    // turn thresholds in degrees
    localparam int NODE_TURN_MIN = 30;
    localparam int ASYM_TURN_MIN = 45;
    localparam int STRAIGHT_DEG  = 180;

    // strokes of this many points or fewer come out unmarked
    localparam int SHORT_STROKE_MAX = 3;

    // saturating point counter
    localparam int SEEN_BITS = 3;
    localparam int SEEN_MAX  = 7;

    // results one point can release
    localparam int MAX_RESULTS = 3;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // flag part of one result
    typedef struct packed {
        logic node;
        logic asym;
        logic last;
    } flags_t;

endpackage

// ===== rtl/scnm_ifs.sv =====
// ----------------------------------------------------------------------------
// scnm_ifs
// valid/ready channels for stroke points and marked results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scnm_point_if #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           pos_x;
    logic [COORD_BITS-1:0]           pos_y;
    logic [scnm_pkg::ANGLE_BITS-1:0] angle_in;
    logic [scnm_pkg::ANGLE_BITS-1:0] angle_out;
    logic                            angles_known;
    logic                            stroke_closed;
    logic                            stroke_end;

    modport source (
        output valid, pos_x, pos_y, angle_in, angle_out,
        output angles_known, stroke_closed, stroke_end,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, angle_in, angle_out,
        input  angles_known, stroke_closed, stroke_end,
        output ready
    );
endinterface

interface scnm_result_if #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  node_flag;
    logic                  asym_flag;
    logic                  last_of_stroke;

    modport source (
        output valid, out_x, out_y, node_flag, asym_flag, last_of_stroke,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, node_flag, asym_flag, last_of_stroke,
        output ready
    );
endinterface

// ===== rtl/scnm_input_stage.sv =====
// ----------------------------------------------------------------------------
// scnm_input_stage
// input register for one point, released when the result queue has room
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scnm_input_stage #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    scnm_point_if.sink                      points,
    input  logic                            room,
    output logic                            advance,
    output logic [COORD_BITS-1:0]           x,
    output logic [COORD_BITS-1:0]           y,
    output logic [scnm_pkg::ANGLE_BITS-1:0] ang_in,
    output logic [scnm_pkg::ANGLE_BITS-1:0] ang_out,
    output logic                            known,
    output logic                            closed,
    output logic                            last
);

    logic                            valid_reg;
    logic [COORD_BITS-1:0]           x_reg;
    logic [COORD_BITS-1:0]           y_reg;
    logic [scnm_pkg::ANGLE_BITS-1:0] ang_in_reg;
    logic [scnm_pkg::ANGLE_BITS-1:0] ang_out_reg;
    logic                            known_reg;
    logic                            closed_reg;
    logic                            last_reg;
    logic                            load;

    assign advance      = valid_reg && room;
    assign points.ready = !valid_reg || advance;
    assign load         = points.valid && points.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (points.ready)
        begin
            valid_reg <= points.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg       <= points.pos_x;
            y_reg       <= points.pos_y;
            ang_in_reg  <= points.angle_in;
            ang_out_reg <= points.angle_out;
            known_reg   <= points.angles_known;
            closed_reg  <= points.stroke_closed;
            last_reg    <= points.stroke_end;
        end
    end

    assign x       = x_reg;
    assign y       = y_reg;
    assign ang_in  = ang_in_reg;
    assign ang_out = ang_out_reg;
    assign known   = known_reg;
    assign closed  = closed_reg;
    assign last    = last_reg;

endmodule

// ===== rtl/scnm_marker_core.sv =====
// ----------------------------------------------------------------------------
// scnm_marker_core
// two-point window, node and asymmetry marking, demotion and stroke flush
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scnm_marker_core #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [COORD_BITS-1:0]           x,
    input  logic [COORD_BITS-1:0]           y,
    input  logic [scnm_pkg::ANGLE_BITS-1:0] ang_in,
    input  logic [scnm_pkg::ANGLE_BITS-1:0] ang_out,
    input  logic                            known,
    input  logic                            closed,
    input  logic                            last,
    output logic [COORD_BITS-1:0]           res_x [scnm_pkg::MAX_RESULTS],
    output logic [COORD_BITS-1:0]           res_y [scnm_pkg::MAX_RESULTS],
    output scnm_pkg::flags_t                res_flags [scnm_pkg::MAX_RESULTS],
    output logic [1:0]                      push_cnt
);

    localparam int AB = scnm_pkg::ANGLE_BITS;
    localparam int SB = scnm_pkg::SEEN_BITS;

    function automatic logic [1:0] step_sign(
        input logic [COORD_BITS-1:0] from_v,
        input logic [COORD_BITS-1:0] to_v
    );
        logic [1:0] s;
        if (to_v > from_v)
            s = 2'b01;
        else if (to_v < from_v)
            s = 2'b10;
        else
            s = 2'b00;
        return s;
    endfunction

    // window of pending points, no reset
    logic [COORD_BITS-1:0] ex_reg    [2];
    logic [COORD_BITS-1:0] ey_reg    [2];
    logic                  enode_reg [2];
    logic                  easym_reg [2];

    logic [1:0]    cnt_reg, cnt_next;
    logic [SB-1:0] seen_reg, seen_next;
    logic [3:0]    signs_reg, signs_next;
    logic          demoted_reg, demoted_next;
    logic          prev_node_reg, prev_node_next;
    logic          closed_reg, closed_next;

    logic                  first_pt;
    logic                  cl;
    logic [COORD_BITS-1:0] px, py;
    logic [3:0]            signs;
    logic                  flip;
    logic                  n0, n1, a0, a1;
    logic                  d0, d1;
    logic signed [AB:0]    a_diff;
    logic [AB-1:0]         a_abs;
    logic signed [AB:0]    t_diff;
    logic [AB-1:0]         t_abs;
    logic                  turn_ok;
    logic                  new_node, new_asym;
    logic [SB-1:0]         seen_inc;
    logic                  long_stroke;
    logic                  full;

    always_comb
    begin
        first_pt = (seen_reg == '0);
        cl       = first_pt ? closed : closed_reg;
        full     = (cnt_reg == 2'd2);

        // step direction from the newest buffered point
        px    = full ? ex_reg[1] : ex_reg[0];
        py    = full ? ey_reg[1] : ey_reg[0];
        signs = {step_sign(py, y), step_sign(px, x)};
        flip  = full && (signs != signs_reg);

        // turn measure | |in - out| - 180 |
        a_diff  = $signed({1'b0, ang_in}) - $signed({1'b0, ang_out});
        a_abs   = a_diff[AB] ? AB'(-a_diff) : a_diff[AB-1:0];
        t_diff  = $signed({1'b0, a_abs}) - $signed((AB+1)'(scnm_pkg::STRAIGHT_DEG));
        t_abs   = t_diff[AB] ? AB'(-t_diff) : t_diff[AB-1:0];
        turn_ok = (seen_reg >= SB'(2)) && known;

        if (first_pt)
        begin
            new_node = 1'b1;
            new_asym = !closed;
        end
        else
        begin
            new_node = turn_ok && (t_abs >= AB'(scnm_pkg::NODE_TURN_MIN));
            new_asym = turn_ok && (t_abs >= AB'(scnm_pkg::ASYM_TURN_MIN));
        end

        seen_inc    = (seen_reg == SB'(scnm_pkg::SEEN_MAX)) ? seen_reg : seen_reg + SB'(1);
        long_stroke = (seen_inc > SB'(scnm_pkg::SHORT_STROKE_MAX));

        n0 = enode_reg[0];
        a0 = easym_reg[0];
        n1 = enode_reg[1] | flip;
        a1 = easym_reg[1];

        // demotion chain over the emitted points
        d0 = prev_node_reg && !demoted_reg && n0 && n1 && !a0;
        d1 = n0 && !d0 && n1 && !a1;

        res_x[0] = (cnt_reg == 2'd0) ? x : ex_reg[0];
        res_y[0] = (cnt_reg == 2'd0) ? y : ey_reg[0];
        res_x[1] = (cnt_reg == 2'd1) ? x : ex_reg[1];
        res_y[1] = (cnt_reg == 2'd1) ? y : ey_reg[1];
        res_x[2] = x;
        res_y[2] = y;

        for (int k = 0; k < scnm_pkg::MAX_RESULTS; k++)
        begin
            res_flags[k] = '0;
        end

        cnt_next       = cnt_reg;
        seen_next      = seen_inc;
        signs_next     = (cnt_reg != 2'd0) ? signs : signs_reg;
        demoted_next   = demoted_reg;
        prev_node_next = prev_node_reg;
        closed_next    = cl;
        push_cnt       = 2'd0;

        if (last)
        begin
            cnt_next       = 2'd0;
            seen_next      = '0;
            signs_next     = '0;
            demoted_next   = 1'b0;
            prev_node_next = 1'b0;
            closed_next    = 1'b0;
            if (long_stroke)
            begin
                res_flags[0] = '{node: n0 && !d0, asym: a0, last: 1'b0};
                res_flags[1] = '{node: n1 && !d1, asym: a1, last: 1'b0};
                res_flags[2] = '{node: 1'b1, asym: new_asym || !cl, last: 1'b1};
                push_cnt     = 2'd3;
            end
            else
            begin
                // short stroke: unmarked, last flag on the newest point
                res_flags[0].last = (cnt_reg == 2'd0);
                res_flags[1].last = (cnt_reg == 2'd1);
                res_flags[2].last = full;
                push_cnt          = 2'(cnt_reg + 2'd1);
            end
        end
        else if (full)
        begin
            res_flags[0]   = '{node: n0 && !d0, asym: a0, last: 1'b0};
            push_cnt       = 2'd1;
            demoted_next   = d0;
            prev_node_next = n0;
        end
        else
        begin
            cnt_next = 2'(cnt_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 2'd0;
            seen_reg      <= '0;
            signs_reg     <= '0;
            demoted_reg   <= 1'b0;
            prev_node_reg <= 1'b0;
            closed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            signs_reg     <= signs_next;
            demoted_reg   <= demoted_next;
            prev_node_reg <= prev_node_next;
            closed_reg    <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !last)
        begin
            if (full)
            begin
                // shift the window by one point
                ex_reg[0]    <= ex_reg[1];
                ey_reg[0]    <= ey_reg[1];
                enode_reg[0] <= n1;
                easym_reg[0] <= a1;
                ex_reg[1]    <= x;
                ey_reg[1]    <= y;
                enode_reg[1] <= new_node;
                easym_reg[1] <= new_asym;
            end
            else if (cnt_reg == 2'd1)
            begin
                ex_reg[1]    <= x;
                ey_reg[1]    <= y;
                enode_reg[1] <= new_node;
                easym_reg[1] <= new_asym;
            end
            else
            begin
                ex_reg[0]    <= x;
                ey_reg[0]    <= y;
                enode_reg[0] <= new_node;
                easym_reg[0] <= new_asym;
            end
        end
    end

endmodule

// ===== rtl/scnm_result_queue.sv =====
// ----------------------------------------------------------------------------
// scnm_result_queue
// small result fifo taking up to three results a cycle, one out a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scnm_result_queue #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [1:0]            push_cnt,
    input  logic [COORD_BITS-1:0] res_x [scnm_pkg::MAX_RESULTS],
    input  logic [COORD_BITS-1:0] res_y [scnm_pkg::MAX_RESULTS],
    input  scnm_pkg::flags_t      res_flags [scnm_pkg::MAX_RESULTS],
    output logic                  room,
    scnm_result_if.source         results
);

    localparam int PW = scnm_pkg::RQ_PTR_W;
    localparam int CW = scnm_pkg::RQ_CNT_W;

    logic [COORD_BITS-1:0] qx_reg [scnm_pkg::RQ_DEPTH];
    logic [COORD_BITS-1:0] qy_reg [scnm_pkg::RQ_DEPTH];
    scnm_pkg::flags_t      qf_reg [scnm_pkg::RQ_DEPTH];

    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [1:0]    n_in;

    assign room = (count_reg <= CW'(scnm_pkg::RQ_DEPTH - scnm_pkg::MAX_RESULTS));
    assign pop  = results.valid && results.ready;
    assign n_in = push ? push_cnt : 2'd0;

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PW'(n_in);
        count_next  = count_reg + CW'(n_in) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < scnm_pkg::MAX_RESULTS; k++)
        begin
            if (push && (2'(k) < push_cnt))
            begin
                qx_reg[wr_ptr_reg + PW'(k)] <= res_x[k];
                qy_reg[wr_ptr_reg + PW'(k)] <= res_y[k];
                qf_reg[wr_ptr_reg + PW'(k)] <= res_flags[k];
            end
        end
    end

    assign results.valid          = (count_reg != '0);
    assign results.out_x          = qx_reg[rd_ptr_reg];
    assign results.out_y          = qy_reg[rd_ptr_reg];
    assign results.node_flag      = qf_reg[rd_ptr_reg].node;
    assign results.asym_flag      = qf_reg[rd_ptr_reg].asym;
    assign results.last_of_stroke = qf_reg[rd_ptr_reg].last;

endmodule

// ===== rtl/stroke_corner_node_marker.sv =====
// ----------------------------------------------------------------------------
// stroke_corner_node_marker
// marks corner nodes and asymmetric nodes of pen strokes, point by point
// ----------------------------------------------------------------------------
// usage
//   points: one pen point per transaction (coordinates, in/out angles, flags);
//     stroke_end marks the last point of a stroke
//   results: one point per transaction with node_flag, asym_flag and
//     last_of_stroke; points leave in arrival order, two points behind input
//   throughput: one point per cycle while results are taken; a stroke end
//     releases up to three results at once, which drain one per cycle, so
//     the next point can wait in the input register meanwhile
//   path: a point is held in the input register, and the results it
//     releases are offered from the result queue
//   reset: clears window, stroke counters and queue; nothing is offered
//   stall: a stalled results sink fills the four-entry queue; the input
//     register holds its point while fewer than three entries are free, and
//     points.ready drops once that register is occupied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stroke_corner_node_marker #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    scnm_point_if.sink    points,
    scnm_result_if.source results
);

    // registered point
    logic                            advance;
    logic                            room;
    logic [COORD_BITS-1:0]           pt_x;
    logic [COORD_BITS-1:0]           pt_y;
    logic [scnm_pkg::ANGLE_BITS-1:0] pt_ang_in;
    logic [scnm_pkg::ANGLE_BITS-1:0] pt_ang_out;
    logic                            pt_known;
    logic                            pt_closed;
    logic                            pt_last;

    // results released by the current point
    logic [COORD_BITS-1:0] res_x     [scnm_pkg::MAX_RESULTS];
    logic [COORD_BITS-1:0] res_y     [scnm_pkg::MAX_RESULTS];
    scnm_pkg::flags_t      res_flags [scnm_pkg::MAX_RESULTS];
    logic [1:0]            push_cnt;

    // input register, released only when the queue can take a full flush
    scnm_input_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_input (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .room    (room),
        .advance (advance),
        .x       (pt_x),
        .y       (pt_y),
        .ang_in  (pt_ang_in),
        .ang_out (pt_ang_out),
        .known   (pt_known),
        .closed  (pt_closed),
        .last    (pt_last)
    );

    // marking logic and the two-point window
    scnm_marker_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .x         (pt_x),
        .y         (pt_y),
        .ang_in    (pt_ang_in),
        .ang_out   (pt_ang_out),
        .known     (pt_known),
        .closed    (pt_closed),
        .last      (pt_last),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_flags (res_flags),
        .push_cnt  (push_cnt)
    );

    // result queue decouples the results sink from the marking logic
    scnm_result_queue #(
        .COORD_BITS (COORD_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_cnt  (push_cnt),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_flags (res_flags),
        .room      (room),
        .results   (results)
    );

endmodule

// ===== rtl/scnm_checker.sv =====
// ----------------------------------------------------------------------------
// scnm_checker
// port-level checks of the stroke corner node marker, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scnm_checker #(
    parameter int COORD_BITS = scnm_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] out_x,
    input logic [COORD_BITS-1:0] out_y,
    input logic                  node_flag,
    input logic                  asym_flag,
    input logic                  last_of_stroke
);

    // a stalled result transaction stays offered
    `SCNM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // and keeps its payload
    `SCNM_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(node_flag) && $stable(asym_flag) && $stable(last_of_stroke), "stalled result changed")

    // input back-pressure only comes from queued results
    `SCNM_ASSERT(a_bp_cause, clk, rst_n, !in_ready |-> out_valid, "input stalled with no result pending")

    // nothing is offered while reset is applied
    `SCNM_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !out_valid, "result offered during reset")

    // no input transaction is refused while nothing waits on the output
    `SCNM_ASSERT(a_in_flow, clk, rst_n, in_valid && !out_valid |-> in_ready, "input refused with empty output")

endmodule

bind stroke_corner_node_marker scnm_checker #(
    .COORD_BITS (COORD_BITS)
) u_scnm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (points.valid),
    .in_ready       (points.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_x          (results.out_x),
    .out_y          (results.out_y),
    .node_flag      (results.node_flag),
    .asym_flag      (results.asym_flag),
    .last_of_stroke (results.last_of_stroke)
);

// ===== bench/stroke_corner_node_marker_tb.sv =====
// ----------------------------------------------------------------------------
// stroke_corner_node_marker_tb
// self-checking bench for the stroke corner node marker
// ----------------------------------------------------------------------------
// pen strokes go in one point per transaction, with random gaps on the point
// side and random back-pressure on the result side. A software copy of the
// marking rules predicts every marked point; each result transaction is
// checked field by field against the oldest prediction. Stimulus opens with
// hand-built strokes (extremes, thresholds, demotion, short strokes) and then
// runs random strokes of mostly well-formed shape.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stroke_corner_node_marker_tb;

    localparam int CB            = scnm_pkg::COORD_BITS_DEF;
    localparam int AB            = scnm_pkg::ANGLE_BITS;
    localparam int CMAX          = (1 << CB) - 1;
    localparam int RANDOM_POINTS = 250;   // random part stops once this many are queued
    localparam int SETTLE_CYCLES = 10;    // extra wait for stray results after the last one owed
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 64;    // long result-side hold-off
    localparam int HOLD_AT_A     = 40;    // accepted points before the first hold-off
    localparam int HOLD_AT_B     = 170;   // and before the second

    // direction of one coordinate step
    typedef enum logic [1:0] {
        DIR_FLAT = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } step_dir_t;

    // one pen point as offered, plus a bench-only flag that makes the sender
    // wait for every predicted result before offering it
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [AB-1:0] a_in;
        logic [AB-1:0] a_out;
        logic          known;
        logic          closed;
        logic          last_pt;
        logic          drain;
    } pen_pt_t;

    // one marked point as it should leave the block
    typedef struct packed {
        logic [CB-1:0]    x;
        logic [CB-1:0]    y;
        scnm_pkg::flags_t flags;
    } marked_pt_t;

    // one point held in the three-deep marking window
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          node;
        logic          asym;
    } win_pt_t;

    logic clk = 1'b0;
    logic rst_n;

    scnm_point_if  #(.COORD_BITS(CB)) pts ();
    scnm_result_if #(.COORD_BITS(CB)) res ();

    stroke_corner_node_marker #(
        .COORD_BITS(CB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (pts),
        .results (res)
    );

    always #5 clk = ~clk;

    // points waiting to be offered, filled up front by the stimulus block
    pen_pt_t    stroke_q[$];
    // predicted marked points, oldest first
    marked_pt_t marked_q[$];

    // shared bookkeeping; all but fault_cnt are written nonblocking, so that
    // every reader at the same edge sees the value from before it
    int fault_cnt = 0;
    int taken_cnt = 0;
    int owed_cnt  = 0;
    int hold_left = 0;
    int hold_idx  = 0;

    // sender and receiver pacing
    int src_gap   = 0;
    int src_calm  = 0;
    int sink_gap  = 0;
    int sink_calm = 0;

    // ------------------------------------------------------------------------
    // marking model state: window, stroke counters and the flags carried
    // from one released point to the next
    // ------------------------------------------------------------------------
    win_pt_t    win [3]      = '{default: '0};
    int         win_cnt      = 0;
    int         seen_cnt     = 0;     // saturates at SEEN_MAX
    logic [3:0] last_signs   = '0;    // {y dir, x dir} of the previous step
    logic       prev_demoted = 1'b0;
    logic       prev_raw     = 1'b0;  // raw node flag of the last released point
    logic       closed_lat   = 1'b0;  // closed flag of the stroke's first point

    function automatic step_dir_t step_dir(logic [CB-1:0] from, logic [CB-1:0] to);
        if (to > from)
            return DIR_UP;
        if (to < from)
            return DIR_DOWN;
        return DIR_FLAT;
    endfunction

    // release window entry i; a symmetric node squeezed between two nodes is
    // demoted, but never the point right after a demotion
    function automatic void release_point(int i, bit has_next, bit last);
        logic       demote;
        marked_pt_t r;
        demote = has_next && prev_raw && !prev_demoted && win[i].node &&
                 win[i + 1].node && !win[i].asym;
        r.x          = win[i].x;
        r.y          = win[i].y;
        r.flags.node = win[i].node && !demote;
        r.flags.asym = win[i].asym;
        r.flags.last = last;
        marked_q.push_back(r);
        prev_demoted = demote;
        prev_raw     = win[i].node;
    endfunction

    // take one accepted point and queue whatever marked points it releases
    function automatic void mark_point(pen_pt_t p);
        logic [3:0] signs;
        int         turn;
        int         tail;
        int         k;
        logic       node;
        logic       asym;
        marked_pt_t r;
        node = 1'b0;
        asym = 1'b0;
        if (seen_cnt == 0)
            closed_lat = p.closed;

        // a change of step direction makes the previous point a node
        if (win_cnt > 0)
        begin
            tail  = win_cnt - 1;
            signs = {step_dir(win[tail].y, p.y), step_dir(win[tail].x, p.x)};
            if (seen_cnt >= 2 && signs != last_signs)
                win[tail].node = 1'b1;
            last_signs = signs;
        end

        // turn rule from the third point on, measured off a straight line
        if (seen_cnt >= 2 && p.known)
        begin
            turn = int'(p.a_in) - int'(p.a_out);
            if (turn < 0)
                turn = -turn;
            turn = turn - scnm_pkg::STRAIGHT_DEG;
            if (turn < 0)
                turn = -turn;
            node = (turn >= scnm_pkg::NODE_TURN_MIN);
            asym = (turn >= scnm_pkg::ASYM_TURN_MIN);
        end

        // stroke start is always a node, asymmetric on open strokes
        if (seen_cnt == 0)
        begin
            node = 1'b1;
            asym = !closed_lat;
        end

        win[win_cnt] = '{x: p.x, y: p.y, node: node, asym: asym};
        win_cnt++;
        if (seen_cnt < scnm_pkg::SEEN_MAX)
            seen_cnt++;

        if (!p.last_pt)
        begin
            // window full: the oldest point leaves, two points behind input
            if (win_cnt == 3)
            begin
                release_point(0, 1'b1, 1'b0);
                win[0]  = win[1];
                win[1]  = win[2];
                win_cnt = 2;
            end
        end
        else
        begin
            if (seen_cnt <= scnm_pkg::SHORT_STROKE_MAX)
            begin
                // short stroke: flushed without any marks
                for (k = 0; k < win_cnt; k++)
                begin
                    r.x          = win[k].x;
                    r.y          = win[k].y;
                    r.flags.node = 1'b0;
                    r.flags.asym = 1'b0;
                    r.flags.last = (k + 1 == win_cnt);
                    marked_q.push_back(r);
                end
            end
            else
            begin
                // stroke end is a node, asymmetric on open strokes
                win[win_cnt - 1].node = 1'b1;
                if (!closed_lat)
                    win[win_cnt - 1].asym = 1'b1;
                for (k = 0; k < win_cnt; k++)
                    release_point(k, k + 1 < win_cnt, k + 1 == win_cnt);
            end
            win_cnt      = 0;
            seen_cnt     = 0;
            last_signs   = '0;
            prev_demoted = 1'b0;
            prev_raw     = 1'b0;
            closed_lat   = 1'b0;
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic void queue_point(int x, int y, int a_in, int a_out, bit known,
                                        bit closed, bit last_pt, bit drain);
        pen_pt_t p;
        p.x       = x[CB-1:0];
        p.y       = y[CB-1:0];
        p.a_in    = a_in[AB-1:0];
        p.a_out   = a_out[AB-1:0];
        p.known   = known;
        p.closed  = closed;
        p.last_pt = last_pt;
        p.drain   = drain;
        stroke_q.push_back(p);
    endfunction

    // ------------------------------------------------------------------------
    // point driver: holds a point until its transaction completes, then idles
    // for a random gap; a point flagged for draining waits until valid has
    // dropped and every predicted result has come out
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic    offer;
        pen_pt_t nxt;
        if (rst_n)
        begin
            offer = pts.valid && !pts.ready;
            if (!offer)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (stroke_q.size() > 0 &&
                         (!stroke_q[0].drain || (!pts.valid && owed_cnt == 0)))
                begin
                    nxt = stroke_q.pop_front();
                    pts.pos_x         <= nxt.x;
                    pts.pos_y         <= nxt.y;
                    pts.angle_in      <= nxt.a_in;
                    pts.angle_out     <= nxt.a_out;
                    pts.angles_known  <= nxt.known;
                    pts.stroke_closed <= nxt.closed;
                    pts.stroke_end    <= nxt.last_pt;
                    offer = 1'b1;
                    // calm stretches: a run of back-to-back points
                    src_gap  = (src_calm > 0) ? 0 : next_gap();
                    src_calm = (src_calm > 0) ? src_calm - 1 :
                               (($urandom_range(0, 49) == 0) ? 40 : 0);
                end
            end
            pts.valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random back-pressure after each transaction, and
    // nothing taken at all while a long hold-off runs
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic take;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                sink_gap  = (sink_calm > 0) ? 0 : next_gap();
                sink_calm = (sink_calm > 0) ? sink_calm - 1 :
                            (($urandom_range(0, 49) == 0) ? 40 : 0);
            end
            if (hold_left != 0)
                take = 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            res.ready <= take;
        end
    end

    // long hold-offs, counted here so the sender keeps offering meanwhile and
    // the block fills its result queue and stalls its point input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (hold_idx < 2 &&
                     taken_cnt >= ((hold_idx == 0) ? HOLD_AT_A : HOLD_AT_B))
            begin
                hold_left <= HOLD_CYCLES;
                hold_idx  <= hold_idx + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks the result transaction first, then feeds the accepted
    // point to the model, so a result can never match its own point's edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pen_pt_t    took;
        marked_pt_t want;
        marked_pt_t got;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                got.x          = res.out_x;
                got.y          = res.out_y;
                got.flags.node = res.node_flag;
                got.flags.asym = res.asym_flag;
                got.flags.last = res.last_of_stroke;
                if (marked_q.size() == 0)
                begin
                    if (fault_cnt < REPORT_LIMIT)
                        $display("%0t: unexpected result x=%0d y=%0d node=%b asym=%b last=%b",
                                 $realtime, got.x, got.y, got.flags.node,
                                 got.flags.asym, got.flags.last);
                    fault_cnt++;
                end
                else
                begin
                    want = marked_q.pop_front();
                    if (got !== want)
                    begin
                        if (fault_cnt < REPORT_LIMIT)
                            $display({"%0t: mismatch expected x=%0d y=%0d node=%b asym=%b ",
                                      "last=%b, got x=%0d y=%0d node=%b asym=%b last=%b"},
                                     $realtime, want.x, want.y, want.flags.node,
                                     want.flags.asym, want.flags.last, got.x, got.y,
                                     got.flags.node, got.flags.asym, got.flags.last);
                        fault_cnt++;
                    end
                end
            end
            if (pts.valid && pts.ready)
            begin
                took.x       = pts.pos_x;
                took.y       = pts.pos_y;
                took.a_in    = pts.angle_in;
                took.a_out   = pts.angle_out;
                took.known   = pts.angles_known;
                took.closed  = pts.stroke_closed;
                took.last_pt = pts.stroke_end;
                took.drain   = 1'b0;
                mark_point(took);
                taken_cnt <= taken_cnt + 1;
            end
            owed_cnt <= marked_q.size();
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of test
    // ------------------------------------------------------------------------
    initial
    begin
        int rand_cnt;
        int total_pts;
        int len;
        int roll;
        int k;
        int cx;
        int cy;
        int dx;
        int dy;
        int a_in;
        int a_out;
        int turn;
        bit closed;
        bit drain;

        rst_n            <= 1'b0;
        pts.valid         = 1'b0;
        pts.pos_x         = '0;
        pts.pos_y         = '0;
        pts.angle_in      = '0;
        pts.angle_out     = '0;
        pts.angles_known  = 1'b0;
        pts.stroke_closed = 1'b0;
        pts.stroke_end    = 1'b0;
        res.ready         = 1'b0;

        // single-point closed stroke at the coordinate and angle extremes
        queue_point(CMAX, 0, 511, 0, 1, 1, 1, 0);
        // two-point open stroke, unknown then known angles
        queue_point(0, CMAX, 0, 511, 0, 0, 0, 0);
        queue_point(CMAX, CMAX, 359, 359, 1, 0, 1, 0);
        // three-point stroke with sharp turns and a direction change: unmarked
        queue_point(100, 100, 0, 0, 1, 0, 0, 0);
        queue_point(90, 110, 0, 0, 1, 1, 0, 0);
        queue_point(200, 50, 0, 0, 1, 0, 1, 0);
        // open stroke walking right then back left; turns just on and off
        // each threshold, a run of symmetric nodes to exercise demotion, an
        // unknown-angle point, and a reversal of the x step
        queue_point(100, 500, 0, 180, 1, 0, 0, 0);
        queue_point(110, 500, 0, 150, 1, 0, 0, 0);    // turn 30
        queue_point(120, 500, 10, 150, 1, 0, 0, 0);   // turn 40
        queue_point(130, 500, 100, 236, 1, 0, 0, 0);  // turn 44
        queue_point(140, 500, 0, 151, 1, 0, 0, 0);    // turn 29
        queue_point(150, 500, 200, 65, 1, 0, 0, 0);   // turn 45
        queue_point(160, 500, 0, 145, 0, 0, 0, 0);    // angles unknown
        queue_point(150, 500, 300, 90, 1, 0, 0, 0);   // x reverses here
        queue_point(140, 500, 359, 0, 1, 0, 0, 0);    // widest turn
        queue_point(130, 500, 0, 180, 1, 0, 1, 0);
        // closed stroke with flat steps, out-of-range angles and a closed
        // flag that changes after the first point
        queue_point(2048, 2048, 400, 0, 1, 1, 0, 0);
        queue_point(2048, 2048, 480, 100, 1, 0, 0, 0);
        queue_point(2049, 2047, 0, 180, 1, 0, 0, 0);
        queue_point(2049, 2047, 90, 270, 1, 1, 0, 0);
        queue_point(2050, 2046, 511, 511, 1, 1, 0, 0);
        queue_point(2040, 2050, 0, 180, 1, 1, 1, 0);

        // random strokes: mostly medium length, some short, a few long enough
        // to saturate the point counter
        rand_cnt = 0;
        while (rand_cnt < RANDOM_POINTS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                len = $urandom_range(1, 3);
            else if (roll < 85)
                len = $urandom_range(4, 10);
            else if (roll < 95)
                len = $urandom_range(11, 20);
            else
                len = $urandom_range(21, 32);
            closed = 1'($urandom_range(0, 1));
            drain  = (rand_cnt == 0) || ($urandom_range(0, 19) == 0);
            cx     = $urandom_range(0, CMAX);
            cy     = $urandom_range(0, CMAX);
            dx     = int'($urandom_range(0, 40)) - 20;
            dy     = int'($urandom_range(0, 40)) - 20;
            for (k = 0; k < len; k++)
            begin
                // steps change now and then, so direction changes stay sparse
                if ($urandom_range(0, 3) == 0)
                    dx = int'($urandom_range(0, 40)) - 20;
                if ($urandom_range(0, 3) == 0)
                    dy = int'($urandom_range(0, 40)) - 20;
                cx = cx + dx;
                cy = cy + dy;
                if (cx < 0)
                    cx = 0;
                if (cx > CMAX)
                    cx = CMAX;
                if (cy < 0)
                    cy = 0;
                if (cy > CMAX)
                    cy = CMAX;

                // pick the turn first; the same turn results whichever way
                // the outgoing angle wraps around the circle
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    turn = $urandom_range(0, 29);
                else if (roll < 75)
                    turn = $urandom_range(30, 44);
                else
                    turn = $urandom_range(45, scnm_pkg::STRAIGHT_DEG);
                a_in  = $urandom_range(0, 359);
                a_out = (a_in + scnm_pkg::STRAIGHT_DEG +
                         ($urandom_range(0, 1) ? turn : -turn) + 360) % 360;
                // occasional raw 9-bit angles
                if ($urandom_range(0, 19) == 0)
                begin
                    a_in  = $urandom_range(0, 511);
                    a_out = $urandom_range(0, 511);
                end

                queue_point(cx, cy, a_in, a_out, $urandom_range(0, 9) != 0,
                            (k == 0 || $urandom_range(0, 9) != 0) ? closed : !closed,
                            k == len - 1, drain && k == 0);
            end
            rand_cnt += len;
        end
        total_pts = stroke_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all points taken, then all predicted results delivered
        while (taken_cnt != total_pts)
            @(posedge clk);
        while (owed_cnt != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (marked_q.size() != 0)
            $display("%0d predicted results never arrived", marked_q.size());
        if (fault_cnt == 0 && marked_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d points queued and %0d results owed",
                 stroke_q.size(), marked_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scnm_pkg.sv
rtl/scnm_ifs.sv
rtl/scnm_input_stage.sv
rtl/scnm_marker_core.sv
rtl/scnm_result_queue.sv
rtl/stroke_corner_node_marker.sv
rtl/scnm_checker.sv
bench/stroke_corner_node_marker_tb.sv
